/* hw/rtl/sha_pkg.sv */
// Shared types, constants and round functions of the SHA-256 byte hasher
`default_nettype none
package sha_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       byte_present;
    logic       message_end;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha_if.sv */
// Valid/ready channel interfaces for message bytes and digest words
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, output byte_value, output byte_present,
                  output message_end, input ready);
  modport sink   (input valid, input byte_value, input byte_present,
                  input message_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sha_front.sv */
// Input stage: takes beats, drops idle items, hands commands to the queue
`default_nettype none
module sha_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  sha_in_if.sink              in_i,
  input  wire sha_pkg::fifo_st_t fifo_st_i,
  output sha_pkg::cmd_t       cmd_o,
  output logic                push_o
);

  logic          stg_valid_q, stg_valid_d;
  sha_pkg::cmd_t stg_q;
  logic          acc;

  assign in_i.ready = !stg_valid_q || !fifo_st_i.full;
  assign acc        = in_i.valid && in_i.ready;
  assign push_o     = stg_valid_q && !fifo_st_i.full;
  assign cmd_o      = stg_q;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_i.ready) begin
      stg_valid_d = acc && (in_i.byte_present || in_i.message_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stg_q <= '{byte_present: in_i.byte_present,
                 message_end:  in_i.message_end,
                 byte_value:   in_i.byte_value};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha_fifo.sv */
// Command queue between the input stage and the compression engine
`default_nettype none
module sha_fifo #(
  parameter int unsigned Depth = sha_pkg::QUEUE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire sha_pkg::cmd_t  cmd_i,
  input  wire                 pop_i,
  output sha_pkg::cmd_t       cmd_o,
  output sha_pkg::fifo_st_t   st_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  sha_pkg::cmd_t   mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign st_o.full  = (cnt_q == CW'(Depth));
  assign st_o.empty = (cnt_q == '0);
  assign cmd_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha_core.sv */
// Block assembly, padding, 64-round compression and digest read-out
`default_nettype none
module sha_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire sha_pkg::cmd_t  cmd_i,
  input  wire sha_pkg::fifo_st_t fifo_st_i,
  output logic                pop_o,
  sha_out_if.source           out_o
);

  typedef enum logic [2:0] {
    S_LOAD, S_PAD80, S_PADZ, S_LEN, S_ROUND, S_FINAL, S_OUT
  } state_e;

  state_e        state_q, state_d, ret_q, ret_d;
  logic [5:0]    fill_q, fill_d, rnd_q, rnd_d;
  logic [2:0]    idx_q, idx_d;
  logic [60:0]   msg_q, msg_d;
  logic [31:0]   h_q [8];
  logic [31:0]   h_d [8];
  logic [31:0]   v_q [8];
  logic [31:0]   v_d [8];
  logic [511:0]  buf_q, buf_d;
  logic [63:0]   len_q, len_d;
  logic [31:0]   w0, w16, t1, t2;

  assign w0  = buf_q[511:480];
  assign w16 = w0 + sha_pkg::small_sig0(buf_q[479:448]) + buf_q[223:192]
             + sha_pkg::small_sig1(buf_q[63:32]);
  assign t1  = v_q[7] + sha_pkg::big_sig1(v_q[4])
             + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
             + sha_pkg::ROUND_K[rnd_q] + w0;
  assign t2  = sha_pkg::big_sig0(v_q[0])
             + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    msg_d   = msg_q;
    h_d     = h_q;
    v_d     = v_q;
    buf_d   = buf_q;
    len_d   = len_q;
    pop_o   = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (!fifo_st_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.byte_present) begin
            buf_d  = {buf_q[503:0], cmd_i.byte_value};
            fill_d = fill_q + 6'd1;
            msg_d  = msg_q + 61'd1;
          end
          len_d = {msg_d, 3'b000};
          if (cmd_i.byte_present && fill_q == 6'd63) begin
            state_d = S_ROUND;
            ret_d   = cmd_i.message_end ? S_PAD80 : S_LOAD;
            v_d     = h_q;
            rnd_d   = '0;
          end else if (cmd_i.message_end) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        buf_d  = {buf_q[503:0], 8'h80};
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = S_ROUND;
          ret_d   = S_PADZ;
          v_d     = h_q;
          rnd_d   = '0;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (fill_q == 6'd56) begin
          state_d = S_LEN;
        end else begin
          buf_d  = {buf_q[503:0], 8'h00};
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            state_d = S_ROUND;
            ret_d   = S_PADZ;
            v_d     = h_q;
            rnd_d   = '0;
          end
        end
      end
      S_LEN: begin
        buf_d  = {buf_q[503:0], len_q[63:56]};
        len_d  = {len_q[55:0], 8'h00};
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = S_ROUND;
          ret_d   = S_OUT;
          v_d     = h_q;
          rnd_d   = '0;
        end
      end
      S_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        buf_d  = {buf_q[479:0], w16};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            h_d     = sha_pkg::H_INIT;
            msg_d   = '0;
            fill_d  = '0;
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ret_q   <= S_LOAD;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      msg_q   <= '0;
      h_q     <= sha_pkg::H_INIT;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      msg_q   <= msg_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    buf_q <= buf_d;
    len_q <= len_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/sha256_byte_stream_hasher.sv */
// SHA-256 byte stream hasher: top level
// Bytes pass an input stage and a command queue; the engine takes one byte a cycle
// while it loads. A full 64-byte block is loaded, then passes 64 rounds and one add
// in the single shared round unit; no byte is taken until these are done.
// Message end adds padding (at most one byte a cycle, up to 72) and one or two blocks,
// then eight digest beats. Reset loads the initial hash values and empties the queue.
`default_nettype none
module sha256_byte_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QUEUE_DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  sha_pkg::cmd_t     push_cmd, pop_cmd;
  sha_pkg::fifo_st_t fifo_st;
  logic              push, pop;

  sha_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .fifo_st_i (fifo_st),
    .cmd_o     (push_cmd),
    .push_o    (push)
  );

  sha_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .st_o   (fifo_st)
  );

  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (pop_cmd),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty) && !(pop && fifo_st.empty))
    else $error("queue status inconsistent");

  a_word_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_word) |=>
      (out_o.valid && out_o.word_index == $past(out_o.word_index) + 3'd1))
    else $error("digest words not consecutive");

  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> !out_o.valid)
    else $error("digest beats after last word");

endmodule
`default_nettype wire
